// ===== sv/mfd_pkg.sv =====
// Shared types and constants for the MQTT frame delimiter.
// Holds the parser state and result structs; no dependencies.
`timescale 1ns / 1ps

package mfd_pkg;

  // Most remaining-length bytes allowed in one fixed header
  localparam int unsigned MAX_LENGTH_BYTES = 4;

  localparam int unsigned LEN_W   = 28;
  localparam int unsigned TOTAL_W = 29;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned HSIZE_W = 3;

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_TYPE   = 2'd0,
    ROLE_LENGTH = 2'd1,
    ROLE_BODY   = 2'd2,
    ROLE_DROP   = 2'd3
  } role_t;

  typedef struct packed {
    phase_t             phase;
    logic [3:0]         held_type;
    logic [3:0]         held_flags;
    logic [LEN_W-1:0]   length_accum;
    logic [COUNT_W-1:0] length_byte_count;
    logic [LEN_W-1:0]   body_left;
  } mfd_state_t;

  typedef struct packed {
    role_t              byte_role;
    logic               header_done;
    logic [3:0]         packet_type;
    logic [3:0]         packet_flags;
    logic [LEN_W-1:0]   rem_length;
    logic [HSIZE_W-1:0] header_size;
    logic [TOTAL_W-1:0] frame_total;
    logic               frame_end;
    logic               length_error;
  } mfd_result_t;

endpackage

// ===== sv/mfd_decode.sv =====
// Single-pass byte decoder: current parser state plus one byte give the
// next state and the result for that byte. Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_decode (
  input  mfd_pkg::mfd_state_t  st,
  input  logic [7:0]           data_byte,
  output mfd_pkg::mfd_state_t  st_nxt,
  output mfd_pkg::mfd_result_t res
);
  import mfd_pkg::*;

  logic [4:0]         shift_amt;
  logic [LEN_W-1:0]   accum_new;
  logic [COUNT_W-1:0] count_new;
  logic [LEN_W-1:0]   body_dec;
  logic [HSIZE_W-1:0] hsize;

  // Length group lands 7 bits higher per byte already taken
  assign shift_amt = 5'(st.length_byte_count[1:0]) * 5'd7;
  assign accum_new = st.length_accum | (LEN_W'(data_byte[6:0]) << shift_amt);
  assign count_new = st.length_byte_count + COUNT_W'(1);
  assign body_dec  = st.body_left - LEN_W'(1);

  always_comb begin
    st_nxt           = st;
    res.byte_role    = ROLE_TYPE;
    res.header_done  = 1'b0;
    res.packet_type  = st.held_type;
    res.packet_flags = st.held_flags;
    res.rem_length   = '0;
    res.frame_end    = 1'b0;
    res.length_error = 1'b0;
    hsize            = '0;

    case (st.phase)
      PH_LENGTH: begin
        if (st.length_byte_count >= COUNT_W'(MAX_LENGTH_BYTES)) begin
          // one length byte too many: drop it and resync on a type byte
          res.byte_role    = ROLE_DROP;
          res.length_error = 1'b1;
          st_nxt.phase     = PH_TYPE;
        end else begin
          st_nxt.length_accum      = accum_new;
          st_nxt.length_byte_count = count_new;
          res.byte_role            = ROLE_LENGTH;
          if (!data_byte[7]) begin
            res.header_done = 1'b1;
            hsize           = HSIZE_W'(1) + count_new;
            if (accum_new == '0) begin
              // empty body: frame ends on this byte
              res.frame_end = 1'b1;
              st_nxt.phase  = PH_TYPE;
            end else begin
              res.rem_length   = accum_new;
              st_nxt.body_left = accum_new;
              st_nxt.phase     = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        st_nxt.body_left = body_dec;
        res.byte_role    = ROLE_BODY;
        res.rem_length   = st.length_accum;
        hsize            = HSIZE_W'(1) + st.length_byte_count;
        res.frame_end    = (body_dec == '0);
        if (body_dec == '0) begin
          st_nxt.phase = PH_TYPE;
        end
      end
      default: begin
        // type byte; the unused phase code lands here too
        st_nxt.phase             = PH_LENGTH;
        st_nxt.held_type         = data_byte[7:4];
        st_nxt.held_flags        = data_byte[3:0];
        st_nxt.length_accum      = '0;
        st_nxt.length_byte_count = '0;
        st_nxt.body_left         = '0;
        res.packet_type          = data_byte[7:4];
        res.packet_flags         = data_byte[3:0];
      end
    endcase

    res.header_size = hsize;
    res.frame_total = (hsize == '0) ? '0
                    : (TOTAL_W'(hsize) + TOTAL_W'(res.rem_length));
  end

endmodule

// ===== sv/mqtt_frame_delimiter.sv =====
// MQTT frame delimiter top level: parser state registers and output register.
// Depends on mfd_pkg and mfd_decode.
`timescale 1ns / 1ps

// Labels each byte of an MQTT stream as type, remaining-length, body or
// dropped byte, decodes the remaining length (up to four bytes) and marks the
// last byte of every frame on out_tlast. One byte is accepted per clock cycle
// while in_tready is high; each result appears in the cycle after its byte, set by the single register
// stage behind the state-update logic. in_tready stays high while the output
// register is empty or is being emptied in the same cycle.
module mqtt_frame_delimiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [0] header_done, [4:1] packet_type,
                                  // [8:5] packet_flags, [36:9] rem_length,
                                  // [39:37] header_size, [68:40] frame_total,
                                  // [69] length_error, [71:70] zero
  output logic [1:0]  out_tuser,  // [1:0] byte_role
  output logic        out_tlast   // frame_end
);
  import mfd_pkg::*;

  mfd_state_t  state_r;
  mfd_state_t  state_nxt;
  mfd_result_t res;
  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        out_last_r;
  logic        in_take;

  mfd_decode u_decode (
    .st        (state_r),
    .data_byte (in_tdata),
    .st_nxt    (state_nxt),
    .res       (res)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_take   = in_tvalid && in_tready;

  // Parser state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase             <= PH_TYPE;
      state_r.held_type         <= '0;
      state_r.held_flags        <= '0;
      state_r.length_accum      <= '0;
      state_r.length_byte_count <= '0;
      state_r.body_left         <= '0;
      out_valid_r               <= 1'b0;
    end else begin
      if (in_take) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= {2'b00, res.length_error, res.frame_total, res.header_size,
                     res.rem_length, res.packet_flags, res.packet_type,
                     res.header_done};
      out_user_r <= res.byte_role;
      out_last_r <= res.frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
